[rtl/core/ngga_pkg.sv]
// ----------------------------------------------------------------------------
// ngga_pkg: shared types and constants of the GGA sentence parser
// Character codes, status codes and the field parse result struct.
// ----------------------------------------------------------------------------
`default_nettype none
package ngga_pkg;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	localparam logic [1:0] ST_GGA   = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_OTHER = 2'd2;

	localparam logic [2:0] PH_BODY = 3'd0;
	localparam logic [2:0] PH_HEX1 = 3'd1;
	localparam logic [2:0] PH_HEX2 = 3'd2;
	localparam logic [2:0] PH_CR   = 3'd3;
	localparam logic [2:0] PH_LF   = 3'd4;

	localparam logic [3:0] FN_TAG = 4'd0;
	localparam logic [3:0] FN_LAT = 4'd2;
	localparam logic [3:0] FN_NS  = 4'd3;
	localparam logic [3:0] FN_LON = 4'd4;
	localparam logic [3:0] FN_EW  = 4'd5;
	localparam logic [3:0] FN_FIX = 4'd6;
	localparam logic [3:0] FN_ALT = 4'd9;

	localparam logic [15:0] LAT_INT_MAX = 16'd9000;
	localparam logic [15:0] LON_INT_MAX = 16'd18000;
	localparam logic [15:0] ALT_INT_MAX = 16'd3275;
	localparam logic [13:0] FRAC_MAX    = 14'd9999;
	localparam logic [13:0] FRAC_SAT    = 14'd10000;
	localparam logic [15:0] INT_SAT     = 16'd65535;

	// Per-field numeric accumulator state.
	typedef struct packed {
		logic [7:0]  chars;
		logic [15:0] int_acc;
		logic [13:0] frac_acc;
		logic [2:0]  frac_cnt;
		logic        dot;
		logic        err;
		logic        minus;
	} field_t;

	function automatic logic [7:0] tag_char(input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		unique case (i)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = 8'h47;
			3'd4: r = 8'h47;
			3'd5: r = 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

[rtl/core/ngga_field.sv]
// ----------------------------------------------------------------------------
// ngga_field: field value conversion
// Turns closed numeric field state into position, fix and altitude values.
// ----------------------------------------------------------------------------
`default_nettype none
module ngga_field
	import ngga_pkg::*;
(
	input  wire field_t       fld,
	output logic [26:0]       lat_mag,
	output logic [26:0]       lon_mag,
	output logic [2:0]        fix_val,
	output logic [15:0]       alt_val
);
	logic        pos_ok;
	logic [13:0] frac4;
	logic [28:0] q_prod;
	logic [9:0]  deg;
	logic [26:0] base;
	logic [15:0] alt_mag;

	always_comb begin
		pos_ok = !fld.err && fld.dot && (fld.frac_cnt != 3'd0) && (fld.frac_acc <= FRAC_MAX);
		unique case (fld.frac_cnt)
			3'd1: frac4 = 14'(fld.frac_acc * 14'd1000);
			3'd2: frac4 = 14'(fld.frac_acc * 14'd100);
			3'd3: frac4 = 14'(fld.frac_acc * 14'd10);
			default: frac4 = fld.frac_acc;
		endcase
		// Degrees are the integer part divided by 100, done by a reciprocal
		// multiply that is exact for integer parts below 43690, which covers
		// every value that passes the range checks.
		q_prod = 29'(fld.int_acc) * 29'd5243;
		deg = q_prod[28:19];
		// ddmm -> minutes * 10000 is int * 10000 - deg * 400000.
		base = 27'(32'(fld.int_acc) * 32'd10000 - 32'(deg) * 32'd400000 + 32'(frac4));
		lat_mag = (pos_ok && fld.int_acc <= LAT_INT_MAX) ? base : '0;
		lon_mag = (pos_ok && fld.int_acc <= LON_INT_MAX) ? base : '0;
		fix_val = (fld.err || fld.dot || fld.chars == 8'd0 || fld.int_acc > 16'd6)
			? 3'd0 : fld.int_acc[2:0];
		alt_mag = 16'(fld.int_acc * 16'd10) + 16'(fld.frac_acc);
		if (fld.err || !fld.dot || fld.frac_cnt == 3'd0 || fld.int_acc > ALT_INT_MAX
			|| fld.frac_acc > 14'd9) begin
			alt_val = '0;
		end else begin
			alt_val = fld.minus ? 16'(-alt_mag) : alt_mag;
		end
	end
endmodule
`default_nettype wire

[rtl/core/nmea_gga_position_parser_top.sv]
// ----------------------------------------------------------------------------
// nmea_gga_position_parser_top: NMEA GGA sentence parser
// Checks framing and checksum of each line and extracts the committed fix.
// ----------------------------------------------------------------------------
// Result: a line feed item's result is registered and shows in the cycle after acceptance.
// Throughput: one item per cycle while the result slot is empty or being drained.
// Reset (arst_n low) clears line state, saved fix and sticky flags at once.
// The result register is a single stage; it frees when the result is taken.
`default_nettype none
module nmea_gga_position_parser_top
	import ngga_pkg::*;
#(
	parameter int LINE_LIMIT  = 128,
	parameter int FIELD_LIMIT = 15
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire  [7:0]        rx_byte,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [1:0]        line_status,
	output logic [2:0]        fix_quality,
	output logic signed [26:0] latitude,
	output logic signed [27:0] longitude,
	output logic signed [15:0] altitude,
	output logic              fix_found,
	output logic              info_received
);
	// Line state.
	logic [7:0]  len_q;
	logic [2:0]  phase_q;
	logic        bad_q, tag_q, ended_q;
	logic [7:0]  xor_q, csum_q;
	logic [3:0]  fn_q;
	field_t      fld_q;
	logic [2:0]  pfix_q;
	logic [26:0] plat_q, plon_q;
	logic [15:0] palt_q;
	logic [1:0]  hemi_q;
	// Committed fix.
	logic [2:0]  sfix_q;
	logic [26:0] slat_q;
	logic [27:0] slon_q;
	logic [15:0] salt_q;
	logic [1:0]  sticky_q;

	logic [26:0] c_lat, c_lon;
	logic [2:0]  c_fix;
	logic [15:0] c_alt;

	ngga_field u_field (
		.fld(fld_q), .lat_mag(c_lat), .lon_mag(c_lon), .fix_val(c_fix), .alt_val(c_alt)
	);

	// The parser accepts while the result slot is empty or being drained.
	assign in_ready = !out_valid || out_ready;
	logic acc;
	assign acc = in_valid && in_ready;

	// Effective state after an overlong restart.
	logic        restart;
	logic [7:0]  e_len;
	logic [2:0]  e_phase;
	logic        e_bad, e_tag, e_ended;
	logic [7:0]  e_xor, e_csum;
	logic [3:0]  e_fn;
	field_t      e_fld;
	logic [2:0]  e_pfix;
	logic [26:0] e_plat, e_plon;
	logic [15:0] e_palt;
	logic [1:0]  e_hemi;

	// Next state.
	logic [7:0]  n_len;
	logic [2:0]  n_phase;
	logic        n_bad, n_tag, n_ended;
	logic [7:0]  n_xor, n_csum;
	logic [3:0]  n_fn;
	field_t      n_fld;
	logic [2:0]  n_pfix;
	logic [26:0] n_plat, n_plon;
	logic [15:0] n_palt;
	logic [1:0]  n_hemi;
	logic        n_start;

	logic        first, is_lf, close, is_digit, numeric, is_hex;
	logic [3:0]  hexv;
	logic [3:0]  dig;
	logic [19:0] iprod;
	logic [17:0] fprod;
	logic        good, gga, commit;
	logic [2:0]  cm_fix;

	always_comb begin
		restart  = (32'(len_q) >= LINE_LIMIT);
		e_len    = restart ? 8'd0 : len_q;
		e_phase  = restart ? PH_BODY : phase_q;
		e_bad    = restart ? 1'b0 : bad_q;
		e_tag    = restart ? 1'b1 : tag_q;
		e_ended  = restart ? 1'b0 : ended_q;
		e_xor    = restart ? 8'd0 : xor_q;
		e_csum   = restart ? 8'd0 : csum_q;
		e_fn     = restart ? 4'd0 : fn_q;
		e_fld    = restart ? '0 : fld_q;
		e_pfix   = restart ? 3'd0 : pfix_q;
		e_plat   = restart ? 27'd0 : plat_q;
		e_plon   = restart ? 27'd0 : plon_q;
		e_palt   = restart ? 16'd0 : palt_q;
		e_hemi   = restart ? 2'd0 : hemi_q;

		first = (e_len == 8'd0);
		is_lf = (rx_byte == CH_LF);
		n_len = e_len + 8'd1;
		n_phase = e_phase; n_bad = e_bad; n_tag = e_tag; n_ended = e_ended;
		n_xor = e_xor; n_csum = e_csum; n_fn = e_fn; n_fld = e_fld;
		n_pfix = e_pfix; n_plat = e_plat; n_plon = e_plon; n_palt = e_palt;
		n_hemi = e_hemi; n_start = 1'b0;
		close = 1'b0;

		is_digit = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
		dig = rx_byte[3:0];
		numeric = (e_fn == FN_LAT) || (e_fn == FN_LON) || (e_fn == FN_FIX) || (e_fn == FN_ALT);
		iprod = 20'(e_fld.int_acc) * 20'd10 + 20'(dig);
		fprod = 18'(e_fld.frac_acc) * 18'd10 + 18'(dig);
		is_hex = is_digit || ((rx_byte >= 8'h41) && (rx_byte <= 8'h46));
		hexv = is_digit ? dig : 4'(rx_byte - 8'h37);

		// Line feed: verdict uses the pre-byte state.
		good = !e_bad && (e_phase == PH_LF) && (e_xor == e_csum);
		gga = good && e_tag;
		commit = gga && (e_pfix != 3'd0);
		cm_fix = commit ? e_pfix : sfix_q;

		if (is_lf) begin
			n_start = 1'b1;
		end else begin
			if (first && rx_byte != CH_DOLLAR) n_bad = 1'b1;
			unique case (e_phase)
				PH_BODY: begin
					if (rx_byte == CH_STAR) begin
						if (!e_ended) close = 1'b1;
						n_ended = 1'b1;
						n_phase = PH_HEX1;
					end else begin
						if (!first) n_xor = e_xor ^ rx_byte;
						if (!e_ended) begin
							if (rx_byte == 8'h00) begin
								close = 1'b1;
								n_ended = 1'b1;
							end else if (rx_byte == CH_COMMA
								&& 32'(e_fn) < FIELD_LIMIT - 1) begin
								close = 1'b1;
								n_fn = e_fn + 4'd1;
								n_fld = '0;
							end else begin
								if (e_fn == FN_TAG) begin
									if (e_fld.chars >= 8'd6 || tag_char(e_fld.chars[2:0]) != rx_byte)
										n_tag = 1'b0;
								end else if (e_fn == FN_NS || e_fn == FN_EW) begin
									if (e_fld.chars == 8'd0) begin
										if (e_fn == FN_NS && rx_byte == CH_S) n_hemi[0] = 1'b1;
										if (e_fn == FN_EW && rx_byte == CH_W) n_hemi[1] = 1'b1;
									end
								end else if (numeric) begin
									if (e_fn == FN_ALT && e_fld.chars == 8'd0 && rx_byte == CH_MINUS) begin
										n_fld.minus = 1'b1;
									end else if (rx_byte == CH_DOT && !e_fld.dot) begin
										n_fld.dot = 1'b1;
										if (e_fld.chars == (e_fld.minus ? 8'd1 : 8'd0))
											n_fld.err = 1'b1;
									end else if (is_digit) begin
										if (!e_fld.dot) begin
											n_fld.int_acc = (iprod > 20'(INT_SAT)) ? INT_SAT : iprod[15:0];
										end else begin
											n_fld.frac_acc = (fprod > 18'(FRAC_SAT)) ? FRAC_SAT : fprod[13:0];
											if (e_fld.frac_cnt < 3'd7) n_fld.frac_cnt = e_fld.frac_cnt + 3'd1;
										end
									end else begin
										n_fld.err = 1'b1;
									end
								end
								if (e_fld.chars != 8'd255) n_fld.chars = e_fld.chars + 8'd1;
							end
						end
					end
				end
				PH_HEX1, PH_HEX2: begin
					if (!is_hex) begin
						n_bad = 1'b1;
					end else begin
						if (e_phase == PH_HEX1) n_csum = {hexv, 4'h0};
						else n_csum = {e_csum[7:4], hexv};
						n_phase = e_phase + 3'd1;
					end
				end
				PH_CR: begin
					if (rx_byte == CH_CR) n_phase = PH_LF;
					else n_bad = 1'b1;
				end
				default: n_bad = 1'b1;
			endcase
			// Field close: the field state in fld_q is the pre-byte field.
			if (close) begin
				if (e_fn == FN_TAG && e_fld.chars != 8'd6) n_tag = 1'b0;
				if (e_fn == FN_LAT) n_plat = c_lat;
				if (e_fn == FN_LON) n_plon = c_lon;
				if (e_fn == FN_FIX) n_pfix = c_fix;
				if (e_fn == FN_ALT) n_palt = c_alt;
			end
		end
	end

	// Close uses fld_q directly; on restart the field number is the tag, so
	// only the character count matters and it is taken from e_fld.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0; phase_q <= PH_BODY; bad_q <= 1'b0; tag_q <= 1'b1;
			ended_q <= 1'b0; xor_q <= '0; csum_q <= '0; fn_q <= '0; fld_q <= '0;
			pfix_q <= '0; plat_q <= '0; plon_q <= '0; palt_q <= '0; hemi_q <= '0;
			sfix_q <= '0; slat_q <= '0; slon_q <= '0; salt_q <= '0; sticky_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_ready && !(acc && n_start)) out_valid <= 1'b0;
			if (acc) begin
				if (n_start) begin
					len_q <= '0; phase_q <= PH_BODY; bad_q <= 1'b0; tag_q <= 1'b1;
					ended_q <= 1'b0; xor_q <= '0; csum_q <= '0; fn_q <= '0; fld_q <= '0;
					pfix_q <= '0; plat_q <= '0; plon_q <= '0; palt_q <= '0; hemi_q <= '0;
					out_valid <= 1'b1;
					if (commit) begin
						sfix_q <= e_pfix;
						slat_q <= e_hemi[0] ? 27'(-e_plat) : e_plat;
						slon_q <= e_hemi[1] ? 28'(-{1'b0, e_plon}) : {1'b0, e_plon};
						salt_q <= e_palt;
					end
					if (gga) sticky_q <= {1'b1, sticky_q[0] | (cm_fix != 3'd0)};
				end else begin
					len_q <= n_len; phase_q <= n_phase; bad_q <= n_bad; tag_q <= n_tag;
					ended_q <= n_ended; xor_q <= n_xor; csum_q <= n_csum; fn_q <= n_fn;
					fld_q <= n_fld; pfix_q <= n_pfix; plat_q <= n_plat; plon_q <= n_plon;
					palt_q <= n_palt; hemi_q <= n_hemi;
				end
			end
		end
	end

	// Result register: status is captured, fix fields follow the saved fix.
	logic [1:0] st_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_GGA;
		end else if (acc && n_start) begin
			st_q <= gga ? ST_GGA : (good ? ST_OTHER : ST_ERROR);
		end
	end

	assign line_status   = st_q;
	assign fix_quality   = sfix_q;
	assign latitude      = slat_q;
	assign longitude     = slon_q;
	assign altitude      = salt_q;
	assign fix_found     = sticky_q[0];
	assign info_received = sticky_q[1];

	a_fix_implies_info: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q[0] |-> sticky_q[1]) else $error("fix_found without info_received");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (st_q == ST_GGA || st_q == ST_ERROR || st_q == ST_OTHER))
		else $error("bad status");
endmodule
`default_nettype wire
